// File: design/icbd_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the ide card bus decoder
package icbd_pkg;

	// request kinds on the input stream
	typedef enum logic [2:0] {
		OP_CTRL_RD = 3'd0,
		OP_CTRL_WR = 3'd1,
		OP_MEM_RD  = 3'd2,
		OP_MEM_WR  = 3'd3,
		OP_IRQ     = 3'd4
	} op_t;

	// register area targets, address bits 6..5
	localparam logic [1:0] TGT_CLK_RAM = 2'd0;
	localparam logic [1:0] TGT_CLK_REG = 2'd1;
	localparam logic [1:0] TGT_DRV0    = 2'd2;
	localparam logic [1:0] TGT_DRV1    = 2'd3;

	// control bit numbers
	localparam logic [2:0] CB_SRAM_SEL = 3'd1;
	localparam logic [2:0] CB_PAGE_SW  = 3'd2;
	localparam logic [2:0] CB_PAGED    = 3'd3;
	localparam logic [2:0] CB_WPROT    = 3'd5;
	localparam logic [2:0] CB_RESET    = 3'd7;

	// configuration register index
	localparam logic REG_DIP = 1'b0;

	// source of the returned byte
	typedef enum logic [1:0] {
		RS_IMM  = 2'd0,
		RS_SRAM = 2'd1,
		RS_CLK  = 2'd2
	} rsel_t;

	// decoded request: result fields, memory commands, register updates
	typedef struct packed {
		rsel_t       rsel;
		logic [7:0]  rd_imm;
		logic        drv_acc;
		logic        drv_wr;
		logic        drv_grp;
		logic [2:0]  drv_reg;
		logic        drv_wide;
		logic [15:0] drv_wdat;
		logic        drv_rst;
		logic        sram_rd;
		logic        sram_wr;
		logic        sram_paged;
		logic        page_sw;
		logic        clk_rd;
		logic        clk_wr;
		logic        clk_reg;
		logic        cpage_we;
		logic        csel_we;
		logic        wlatch_we;
		logic        rlatch_we;
		logic [7:0]  rlatch_val;
		logic        ssel_we;
		logic        ctrl_we;
		logic [2:0]  ctrl_bit;
		logic        irq_we;
	} dec_t;

endpackage

// File: design/icbd_decode.sv
`timescale 1ns / 1ps
// request decoder: address map, drive latches and control bits
module icbd_decode
	import icbd_pkg::*;
(
	input  op_t         op,
	input  logic [12:0] address,
	input  logic [7:0]  data_byte,
	input  logic        bit_value,
	input  logic [15:0] drive_word,
	input  logic [7:2]  ctrl,
	input  logic        sram_sel,
	input  logic        dip,
	input  logic        irq,
	input  logic [7:0]  read_latch,
	input  logic [7:0]  write_latch,
	input  logic [6:0]  clock_page,
	input  logic [5:0]  clock_select,
	output dec_t        dec
);

	logic       regs;
	logic [1:0] tgt;
	logic [2:0] cbit;

	always_comb begin
		regs = (address[12:8] == 5'd0) && (sram_sel == dip);
		tgt  = address[6:5];
		cbit = address[2:0];
		dec  = '0;
		dec.rsel = RS_IMM;
		dec.sram_paged = ctrl[CB_PAGED] || address[12];
		case (op)
			OP_CTRL_RD: begin
				dec.rd_imm = {ctrl, dip, ~irq};
			end
			OP_CTRL_WR: begin
				if (cbit == CB_SRAM_SEL) begin
					dec.ssel_we = 1'b1;
				end else if (cbit inside {[CB_PAGE_SW:CB_RESET]}) begin
					dec.ctrl_we  = 1'b1;
					dec.ctrl_bit = cbit;
					dec.drv_rst  = (cbit == CB_RESET) && bit_value;
				end
			end
			OP_MEM_RD: begin
				if (!regs) begin
					dec.sram_rd = 1'b1;
					dec.rsel    = RS_SRAM;
				end else begin
					case (tgt)
						TGT_CLK_RAM: begin
							if (address[7]) begin
								dec.rd_imm = {1'b0, clock_page};
							end else begin
								dec.clk_rd = 1'b1;
								dec.rsel   = RS_CLK;
							end
						end
						TGT_CLK_REG: begin
							if (address[4]) begin
								dec.rd_imm = {2'b00, clock_select};
							end else begin
								dec.clk_rd  = 1'b1;
								dec.clk_reg = 1'b1;
								dec.rsel    = RS_CLK;
							end
						end
						default: begin
							if (address[0]) begin
								// odd byte: low byte now, high byte kept for the even read
								dec.rlatch_we = 1'b1;
								if (!address[4]) begin
									dec.drv_acc    = 1'b1;
									dec.drv_grp    = address[5];
									dec.drv_reg    = address[3:1];
									dec.drv_wide   = !address[5] && (address[3:1] == 3'd0);
									dec.rd_imm     = drive_word[7:0];
									dec.rlatch_val = drive_word[15:8];
								end
							end else begin
								dec.rd_imm = read_latch;
							end
						end
					endcase
				end
			end
			OP_MEM_WR: begin
				dec.page_sw = ctrl[CB_PAGE_SW];
				if (!regs) begin
					dec.sram_wr = !ctrl[CB_WPROT];
				end else begin
					case (tgt)
						TGT_CLK_RAM: begin
							dec.cpage_we = address[7];
							dec.clk_wr   = !address[7];
						end
						TGT_CLK_REG: begin
							dec.csel_we = address[4];
							dec.clk_wr  = !address[4];
							dec.clk_reg = 1'b1;
						end
						default: begin
							if (address[0]) begin
								dec.wlatch_we = 1'b1;
							end else begin
								dec.drv_acc  = 1'b1;
								dec.drv_wr   = 1'b1;
								dec.drv_grp  = address[5];
								dec.drv_reg  = address[3:1];
								dec.drv_wide = !address[5] && (address[3:1] == 3'd0);
								dec.drv_wdat = {data_byte, write_latch};
							end
						end
					endcase
				end
			end
			OP_IRQ: begin
				dec.irq_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/ide_card_bus_decoder_top.sv
`timescale 1ns / 1ps
// top level of the ide card bus decoder: state registers, memories, stream stages
// a request is registered into stage 1, then into stage 2, which drives m_tvalid
// throughput: one request per cycle unless stalled; each request makes at most one
// access to the sram or the clock memory, each single-port with registered reads
// reset: control state, pages, latches and clock register valid bits clear at once;
// sram and clock ram contents are not cleared, so no clearing pass is needed
module ide_card_bus_decoder_top
	import icbd_pkg::*;
#(
	parameter int SRAM_PAGES  = 64,
	parameter int CLOCK_PAGES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// address[12:0], data_byte[20:13], bit_value[21], drive_word[37:22], zero[39:38]
	input  logic [39:0] s_tdata,
	// operation[2:0]
	input  logic [2:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], drive_access[8], drive_write[9], drive_group[10],
	// drive_register[13:11], drive_wide[14], drive_write_data[30:15], drive_reset[31]
	output logic [31:0] m_tdata
);

	localparam int SP_W     = $clog2(SRAM_PAGES);
	localparam int SRAM_AW  = SP_W + 13;
	localparam int SP_STEPS = $clog2(4096 / SRAM_PAGES) + 1;
	localparam int CB_W     = (CLOCK_PAGES > 1) ? $clog2(CLOCK_PAGES) : 1;
	localparam int CP_STEPS = $clog2(128 / CLOCK_PAGES) + 1;
	localparam int CM_DEPTH = CLOCK_PAGES * 32 + 64;
	localparam int CM_W     = $clog2(CM_DEPTH);

	// request fields
	op_t         op;
	logic [12:0] addr;
	logic [7:0]  dbyte;
	logic        bval;
	logic [15:0] dword;

	assign op    = op_t'(s_tuser);
	assign addr  = s_tdata[12:0];
	assign dbyte = s_tdata[20:13];
	assign bval  = s_tdata[21];
	assign dword = s_tdata[37:22];

	// architectural state
	logic              dip_q;
	logic [7:2]        ctrl_q;
	logic              ssel_q;
	logic              irq_q;
	logic [7:0]        rlatch_q;
	logic [7:0]        wlatch_q;
	logic [6:0]        cpage_q;
	logic [CB_W-1:0]   cbank_q;     // clock page reduced to the fitted pages
	logic [5:0]        csel_q;
	logic [SP_W-1:0]   spage_q;
	logic [63:0]       creg_vld_q;  // clock registers read as zero until written

	// stream control
	logic v_s1, v_s2;
	logic s2_free, s1_adv, acc;

	assign s2_free  = !v_s2 || m_tready;
	assign s1_adv   = v_s1 && s2_free;
	assign s_tready = !v_s1 || s2_free;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = v_s2;

	// apb: always ready, one register
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DIP);
	assign prdata = (paddr[2] == REG_DIP) ? {31'b0, dip_q} : 32'b0;

	// decode against current state
	dec_t dec;

	icbd_decode u_dec (
		.op           (op),
		.address      (addr),
		.data_byte    (dbyte),
		.bit_value    (bval),
		.drive_word   (dword),
		.ctrl         (ctrl_q),
		.sram_sel     (ssel_q),
		.dip          (dip_q),
		.irq          (irq_q),
		.read_latch   (rlatch_q),
		.write_latch  (wlatch_q),
		.clock_page   (cpage_q),
		.clock_select (csel_q),
		.dec          (dec)
	);

	// address-driven sram page: (address >> 1) mod SRAM_PAGES by restoring steps
	logic [23:0]     prem;
	logic [SP_W-1:0] page_new;
	logic [SP_W-1:0] page_use;

	always_comb begin
		prem = {12'b0, addr[12:1]};
		for (int k = SP_STEPS - 1; k >= 0; k--) begin
			if (prem >= (24'(SRAM_PAGES) << k)) begin
				prem = prem - (24'(SRAM_PAGES) << k);
			end
		end
		page_new = prem[SP_W-1:0];
	end

	// the page switch takes effect before the access of the same write
	assign page_use = dec.page_sw ? page_new : spage_q;

	// clock page written value reduced mod CLOCK_PAGES
	logic [15:0]     crem;
	logic [CB_W-1:0] bank_new;

	always_comb begin
		crem = {9'b0, dbyte[6:0]};
		for (int k = CP_STEPS - 1; k >= 0; k--) begin
			if (crem >= (16'(CLOCK_PAGES) << k)) begin
				crem = crem - (16'(CLOCK_PAGES) << k);
			end
		end
		bank_new = crem[CB_W-1:0];
	end

	// memory addresses
	logic [SRAM_AW-1:0] sram_idx;
	logic [CM_W-1:0]    clk_idx;

	assign sram_idx = dec.sram_paged ? {page_use, addr} : {SP_W'(0), addr};
	assign clk_idx  = dec.clk_reg ? (CM_W'(CLOCK_PAGES * 32) + CM_W'(csel_q))
	                              : CM_W'({cbank_q, addr[4:0]});

	// sram: paged store behind the card window
	logic [7:0] sram_mem [SRAM_PAGES * 8192];
	logic [7:0] sram_rdata_q;

	always_ff @(posedge clk) begin
		if (acc && dec.sram_wr) begin
			sram_mem[sram_idx] <= dbyte;
		end
		if (acc && dec.sram_rd) begin
			sram_rdata_q <= sram_mem[sram_idx];
		end
	end

	// clock memory: paged clock ram, then the clock registers, 64 of them
	logic [7:0] clk_mem [CM_DEPTH];
	logic [7:0] clk_rdata_q;

	always_ff @(posedge clk) begin
		if (acc && dec.clk_wr) begin
			clk_mem[clk_idx] <= dbyte;
		end
		if (acc && dec.clk_rd) begin
			clk_rdata_q <= clk_mem[clk_idx];
		end
	end

	// control state, updated by accepted requests; dip bit set by the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_q      <= 1'b1;
			ctrl_q     <= '0;
			ssel_q     <= 1'b0;
			irq_q      <= 1'b0;
			rlatch_q   <= '0;
			wlatch_q   <= '0;
			cpage_q    <= '0;
			cbank_q    <= '0;
			csel_q     <= '0;
			spage_q    <= '0;
			creg_vld_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				dip_q <= pwdata[0];
			end
			if (acc) begin
				if (dec.ctrl_we) begin
					ctrl_q[dec.ctrl_bit] <= bval;
				end
				if (dec.ssel_we) begin
					ssel_q <= bval;
				end
				if (dec.irq_we) begin
					irq_q <= bval;
				end
				if (dec.rlatch_we) begin
					rlatch_q <= dec.rlatch_val;
				end
				if (dec.wlatch_we) begin
					wlatch_q <= dbyte;
				end
				if (dec.cpage_we) begin
					cpage_q <= dbyte[6:0];
					cbank_q <= bank_new;
				end
				if (dec.csel_we) begin
					csel_q <= dbyte[5:0];
				end
				if (dec.page_sw) begin
					spage_q <= page_new;
				end
				if (dec.clk_wr && dec.clk_reg) begin
					creg_vld_q[csel_q] <= 1'b1;
				end
			end
			// stage valids
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// stage 1 holds the decoded result while memory data comes back
	dec_t       dec_s1;
	logic       clk_ok_s1;
	logic [7:0] rd_mux;
	logic [31:0] res_s2;

	always_comb begin
		case (dec_s1.rsel)
			RS_SRAM: rd_mux = sram_rdata_q;
			RS_CLK:  rd_mux = clk_ok_s1 ? clk_rdata_q : 8'h00;
			default: rd_mux = dec_s1.rd_imm;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dec_s1    <= dec;
			clk_ok_s1 <= !dec.clk_reg || creg_vld_q[csel_q];
		end
		if (s1_adv) begin
			res_s2 <= {dec_s1.drv_rst, dec_s1.drv_wdat, dec_s1.drv_wide, dec_s1.drv_reg,
			           dec_s1.drv_grp, dec_s1.drv_wr, dec_s1.drv_acc, rd_mux};
		end
	end

	assign m_tdata = res_s2;

endmodule
